@@ sv/adpcm2d_pkg.sv @@
// Shared types and constants for the second-order ADPCM decoder.
// Used by every module of the block but adpcm2d_ram; depends on nothing.
package adpcm2d_pkg;

   // action codes of an input transfer
   localparam logic [1:0] ACT_DATA  = 2'd0;
   localparam logic [1:0] ACT_COEF  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;
   localparam logic [1:0] ACT_HIST  = 2'd3;

   localparam int QueueDepth   = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);

   localparam int CoefBooks    = 16;
   localparam int BookBits     = $clog2(CoefBooks);

   localparam logic [4:0] ScaleBias  = 5'd9;
   localparam logic [3:0] DataBytes4 = 4'd8;
   localparam logic [3:0] DataBytes2 = 4'd4;

   localparam logic signed [21:0] SampleMax = 22'sd32767;
   localparam logic signed [21:0] SampleMin = -22'sd32767;

   typedef struct packed {
      logic [1:0]          action;
      logic [7:0]          data_byte;
      logic                two_bit;
      logic                ends;
      logic [4:0]          shift;
      logic [BookBits-1:0] book;
      logic [4:0]          coef_index;
      logic signed [15:0]  coef_value;
      logic signed [15:0]  hist_older;
      logic signed [15:0]  hist_newer;
   } q_entry_type;

   typedef struct packed {
      logic        valid;
      q_entry_type entry;
   } q_push_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

@@ sv/adpcm2d_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module adpcm2d_ram #(
   parameter int DATA_WIDTH = 16,
   parameter int DEPTH      = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0]    wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/adpcm2d_front.sv @@
// Front end: accepts transfers, tracks frame position, absorbs headers.
// Depends on adpcm2d_pkg.
module adpcm2d_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_action,
   input  logic [7:0]                  req_data_byte,
   input  logic [4:0]                  req_coef_index,
   input  logic signed [15:0]          req_coef_value,
   input  logic signed [15:0]          req_hist_older,
   input  logic signed [15:0]          req_hist_newer,
   input  logic                        two_bit_mode,
   input  adpcm2d_pkg::q_stat_type     q_stat,
   output adpcm2d_pkg::q_push_type     q_push
);

   logic [3:0]                       pos_ff,   pos_in;
   logic [4:0]                       shift_ff, shift_in;
   logic [adpcm2d_pkg::BookBits-1:0] book_ff,  book_in;
   logic                             accept;
   logic [3:0]                       data_bytes;
   logic                             ends;

   assign req_ready  = !q_stat.full;
   assign accept     = req_valid && req_ready;
   assign data_bytes = two_bit_mode ? adpcm2d_pkg::DataBytes2 : adpcm2d_pkg::DataBytes4;
   assign ends       = pos_ff >= data_bytes;

   always_comb begin
      pos_in   = pos_ff;
      shift_in = shift_ff;
      book_in  = book_ff;
      q_push.valid            = 1'b0;
      q_push.entry.action     = req_action;
      q_push.entry.data_byte  = req_data_byte;
      q_push.entry.two_bit    = two_bit_mode;
      q_push.entry.ends       = ends;
      q_push.entry.shift      = shift_ff;
      q_push.entry.book       = book_ff;
      q_push.entry.coef_index = req_coef_index;
      q_push.entry.coef_value = req_coef_value;
      q_push.entry.hist_older = req_hist_older;
      q_push.entry.hist_newer = req_hist_newer;
      if (accept) begin
         unique case (req_action)
            adpcm2d_pkg::ACT_DATA: begin
               if (pos_ff == 4'd0) begin
                  // header: latch scale and book, nothing goes downstream
                  shift_in = {1'b0, req_data_byte[7:4]} + adpcm2d_pkg::ScaleBias;
                  book_in  = req_data_byte[3:0];
                  pos_in   = 4'd1;
               end else begin
                  q_push.valid = 1'b1;
                  pos_in       = ends ? 4'd0 : pos_ff + 4'd1;
               end
            end
            adpcm2d_pkg::ACT_CLEAR: begin
               q_push.valid = 1'b1;
               pos_in       = 4'd0;
            end
            default: begin
               q_push.valid = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= 4'd0;
         shift_ff <= 5'd0;
         book_ff  <= '0;
      end else begin
         pos_ff   <= pos_in;
         shift_ff <= shift_in;
         book_ff  <= book_in;
      end
   end

endmodule

@@ sv/adpcm2d_queue.sv @@
// Short in-order queue of classified operations between front and back.
// Depends on adpcm2d_pkg.
module adpcm2d_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  adpcm2d_pkg::q_push_type   q_push,
   input  logic                      pop,
   output adpcm2d_pkg::q_entry_type  head,
   output adpcm2d_pkg::q_stat_type   q_stat
);

   localparam int PtrBits = adpcm2d_pkg::QueuePtrBits;

   adpcm2d_pkg::q_entry_type entries_ff [adpcm2d_pkg::QueueDepth];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrBits:0]   count_ff,  count_in;
   logic               do_push;
   logic               do_pop;

   assign q_stat.full  = count_ff == (PtrBits+1)'(adpcm2d_pkg::QueueDepth);
   assign q_stat.empty = count_ff == '0;
   assign do_push      = q_push.valid && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head         = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= q_push.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ sv/adpcm2d_back.sv @@
// Back end: coefficient store, history and the sample multiply-accumulate loop.
// Depends on adpcm2d_pkg and adpcm2d_ram.
module adpcm2d_back (
   input  logic                      clock,
   input  logic                      reset,
   input  adpcm2d_pkg::q_entry_type  head,
   input  adpcm2d_pkg::q_stat_type   q_stat,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [15:0]        rsp_sample,
   output logic                      rsp_last_of_run,
   output logic                      rsp_frame_end
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_ACC  = 2'd2;
   localparam int BookBits = adpcm2d_pkg::BookBits;

   logic [1:0]                state_ff,   state_in;
   logic signed [15:0]        older_ff,   older_in;
   logic signed [15:0]        newer_ff,   newer_in;
   logic [7:0]                code_sr_ff, code_sr_in;
   logic                      two_bit_ff, two_bit_in;
   logic                      ends_ff,    ends_in;
   logic [4:0]                shift_ff,   shift_in;
   logic [BookBits-1:0]       book_ff,    book_in;
   logic [1:0]                idx_ff,     idx_in;
   logic signed [31:0]        p_old_ff,   p_old_in;
   logic signed [31:0]        p_new_ff,   p_new_in;
   logic                      rsp_valid_ff,  rsp_valid_in;
   logic signed [15:0]        rsp_sample_ff, rsp_sample_in;
   logic                      rsp_last_ff,   rsp_last_in;
   logic                      rsp_end_ff,    rsp_end_in;

   logic                      wr_old, wr_new;
   logic [BookBits-1:0]       rd_addr;
   logic [15:0]               c_old, c_new;
   logic signed [15:0]        m_old, m_new;
   logic signed [31:0]        code32;
   logic signed [31:0]        acc_sum;
   logic signed [21:0]        acc_sh;
   logic signed [15:0]        clamped;
   logic                      last;
   logic                      out_free;

   assign pop    = (state_ff == ST_IDLE) && !q_stat.empty;
   assign wr_old = pop && (head.action == adpcm2d_pkg::ACT_COEF) && !head.coef_index[0];
   assign wr_new = pop && (head.action == adpcm2d_pkg::ACT_COEF) &&  head.coef_index[0];
   assign rd_addr = (state_ff == ST_IDLE) ? head.book : book_ff;

   adpcm2d_ram #(.DATA_WIDTH(16), .DEPTH(adpcm2d_pkg::CoefBooks)) u_coef_old (
      .clock   (clock),
      .wr_en   (wr_old),
      .wr_addr (head.coef_index[4:1]),
      .wr_data (head.coef_value),
      .rd_addr (rd_addr),
      .rd_data (c_old)
   );

   adpcm2d_ram #(.DATA_WIDTH(16), .DEPTH(adpcm2d_pkg::CoefBooks)) u_coef_new (
      .clock   (clock),
      .wr_en   (wr_new),
      .wr_addr (head.coef_index[4:1]),
      .wr_data (head.coef_value),
      .rd_addr (rd_addr),
      .rd_data (c_new)
   );

   // floor(c/4)*2
   assign m_old = {c_old[15], c_old[15:2], 1'b0};
   assign m_new = {c_new[15], c_new[15:2], 1'b0};

   assign code32 = two_bit_ff ? 32'(signed'(code_sr_ff[7:6]))
                              : 32'(signed'(code_sr_ff[7:4]));
   assign acc_sum = (code32 <<< shift_ff) + p_old_ff + p_new_ff;
   assign acc_sh  = acc_sum[31:10];
   assign last    = two_bit_ff ? (idx_ff == 2'd3) : (idx_ff == 2'd1);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      priority if (acc_sh > adpcm2d_pkg::SampleMax) begin
         clamped = 16'(adpcm2d_pkg::SampleMax);
      end else if (acc_sh < adpcm2d_pkg::SampleMin) begin
         clamped = 16'(adpcm2d_pkg::SampleMin);
      end else begin
         clamped = acc_sh[15:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      older_in      = older_ff;
      newer_in      = newer_ff;
      code_sr_in    = code_sr_ff;
      two_bit_in    = two_bit_ff;
      ends_in       = ends_ff;
      shift_in      = shift_ff;
      book_in       = book_ff;
      idx_in        = idx_ff;
      p_old_in      = p_old_ff;
      p_new_in      = p_new_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_end_in    = rsp_end_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               unique case (head.action)
                  adpcm2d_pkg::ACT_DATA: begin
                     code_sr_in = head.data_byte;
                     two_bit_in = head.two_bit;
                     ends_in    = head.ends;
                     shift_in   = head.shift;
                     book_in    = head.book;
                     idx_in     = 2'd0;
                     state_in   = ST_MUL;
                  end
                  adpcm2d_pkg::ACT_CLEAR: begin
                     older_in = '0;
                     newer_in = '0;
                  end
                  adpcm2d_pkg::ACT_HIST: begin
                     older_in = head.hist_older;
                     newer_in = head.hist_newer;
                  end
                  default: begin
                     // coefficient write goes straight to the RAM
                  end
               endcase
            end
         end
         ST_MUL: begin
            p_old_in = 32'(older_ff) * 32'(m_old);
            p_new_in = 32'(newer_ff) * 32'(m_new);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = clamped;
               rsp_last_in   = last;
               rsp_end_in    = last && ends_ff;
               older_in      = newer_ff;
               newer_in      = clamped;
               code_sr_in    = two_bit_ff ? {code_sr_ff[5:0], 2'b00}
                                          : {code_sr_ff[3:0], 4'b0000};
               idx_in        = idx_ff + 2'd1;
               state_in      = last ? ST_IDLE : ST_MUL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         older_ff     <= '0;
         newer_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         older_ff     <= older_in;
         newer_ff     <= newer_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_sr_ff    <= code_sr_in;
      two_bit_ff    <= two_bit_in;
      ends_ff       <= ends_in;
      shift_ff      <= shift_in;
      book_ff       <= book_in;
      idx_ff        <= idx_in;
      p_old_ff      <= p_old_in;
      p_new_ff      <= p_new_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_frame_end   = rsp_end_ff;

endmodule

@@ sv/adpcm_second_order_decoder.sv @@
// Top level of the second-order ADPCM decoder.
// Depends on adpcm2d_pkg, adpcm2d_front, adpcm2d_queue and adpcm2d_back.

// Decodes ADPCM frames fed one byte per transfer. A frame is a header byte
// (high nibble scale, low nibble coefficient book) followed by 8 data bytes
// in 4-bit mode or 4 in 2-bit mode; each data byte yields 2 or 4 clamped
// 16-bit samples, high bits first, with last_of_run on the last sample of
// the byte and frame_end on the sixteenth sample of the frame. The front end
// takes one transfer per cycle while its 4-entry queue has room; headers are
// absorbed there and produce nothing. The back end handles a coefficient
// load, clear or history set in its idle state; each sample of a data byte
// needs a multiply state and an accumulate-and-clamp state because the
// next sample's products depend on the sample just produced. A result
// waits in the output register while the loop keeps going up to the next
// accumulate. Coefficient entries never loaded read as undefined. Write
// csr_wr_data only while the block is idle; the mode is sampled per byte.
module adpcm_second_order_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [7:0]         req_data_byte,
   input  logic [4:0]         req_coef_index,
   input  logic signed [15:0] req_coef_value,
   input  logic signed [15:0] req_hist_older,
   input  logic signed [15:0] req_hist_newer,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample,
   output logic               rsp_last_of_run,
   output logic               rsp_frame_end,
   input  logic               csr_wr_en,
   input  logic               csr_wr_data
);

   logic two_bit_mode_ff, two_bit_mode_in;

   adpcm2d_pkg::q_stat_type  q_stat;
   adpcm2d_pkg::q_push_type  q_push;
   adpcm2d_pkg::q_entry_type q_head;
   logic                     q_pop;

   // mode register: hold unless written
   assign two_bit_mode_in = csr_wr_en ? csr_wr_data : two_bit_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         two_bit_mode_ff <= 1'b0;
      end else begin
         two_bit_mode_ff <= two_bit_mode_in;
      end
   end

   // classify transfers, track frame position
   adpcm2d_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_data_byte  (req_data_byte),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .req_hist_older (req_hist_older),
      .req_hist_newer (req_hist_newer),
      .two_bit_mode   (two_bit_mode_ff),
      .q_stat         (q_stat),
      .q_push         (q_push)
   );

   // decouple front and back in order
   adpcm2d_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .pop    (q_pop),
      .head   (q_head),
      .q_stat (q_stat)
   );

   // run the coefficient store, history and sample loop
   adpcm2d_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (q_head),
      .q_stat          (q_stat),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample      (rsp_sample),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_frame_end   (rsp_frame_end)
   );

   // frame end only ever lands on the last sample of a byte
   a_frame_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_frame_end || rsp_last_of_run))
      else $error("frame_end without last_of_run");

   // the clamp never lets the most negative code through
   a_sample_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_sample != 16'sh8000))
      else $error("sample outside clamp range");

   // queue cannot be full and empty at once
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_stat.full && q_stat.empty))
      else $error("queue status inconsistent");

   // nothing is popped from an empty queue
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("pop from empty queue");

endmodule
